/* design/per_source_notify_throttle_core_defines.svh */
// Assertion macros for the per-source notify throttle checker.
// Used by pnt_checker.sv only; needs nothing else.
`ifndef PER_SOURCE_NOTIFY_THROTTLE_CORE_DEFINES_SVH
`define PER_SOURCE_NOTIFY_THROTTLE_CORE_DEFINES_SVH

// same-cycle implication, reset masks it
`define PNT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pnt check failed: same-cycle implication");

// next-cycle implication, reset masks it
`define PNT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pnt check failed: next-cycle implication");

`endif

/* design/pnt_pkg.sv */
// Shared types and constants for the per-source notify throttle.
// No dependencies; the other design files, all but the assertion macro header, refer to it by scoped names.
`default_nettype none

package pnt_pkg;

	localparam int OP_W      = 1;
	localparam int SRC_W     = 8;
	localparam int LEVEL_W   = 7;
	localparam int TIME_W    = 48;
	localparam int STATUS_W  = 2;
	localparam int SLOT_W    = 11;
	localparam int IVL_S_W   = 12;
	localparam int IVL_MS_W  = 22;
	localparam int MS_PER_S  = 1000;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic               RST_ENABLE   = 1'b1;
	localparam logic [LEVEL_W-1:0] RST_CRITICAL = 7'd15;
	localparam logic [LEVEL_W-1:0] RST_HYST     = 7'd2;
	localparam logic [IVL_S_W-1:0] RST_IVL_S    = 12'd60;
	localparam logic [IVL_MS_W-1:0] RST_IVL_MS  = IVL_MS_W'(60 * MS_PER_S);

	typedef enum logic [OP_W-1:0] {
		OP_LEVEL    = 1'b0,
		OP_COMPLETE = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_NOTIFY     = 2'd0,
		ST_SUPPRESSED = 2'd1,
		ST_RANGE      = 2'd2,
		ST_DONE       = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_ENABLE   = 2'd0,
		REG_CRITICAL = 2'd1,
		REG_HYST     = 2'd2,
		REG_INTERVAL = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic               enable;
		logic [LEVEL_W-1:0] critical;
		logic [LEVEL_W-1:0] hyst;
		logic [IVL_MS_W-1:0] interval_ms;
	} cfg_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] last_level;
		logic [TIME_W-1:0]  last_time;
	} entry_t;

	// table update requested by one item
	typedef struct packed {
		logic record;
		logic clear;
	} upd_t;

endpackage

`default_nettype wire

/* design/pnt_if.sv */
// Valid/ready channel interfaces: level events in, throttle results out.
// Depends on pnt_pkg for field widths.
`default_nettype none

interface pnt_evt_if;
	logic                           valid;
	logic                           ready;
	logic [pnt_pkg::OP_W-1:0]       op;
	// source index; the name source is taken by the modport
	logic [pnt_pkg::SRC_W-1:0]      src;
	logic [pnt_pkg::LEVEL_W-1:0]    level;
	logic [pnt_pkg::TIME_W-1:0]     now_ms;
	logic                           delivered;

	modport source (output valid, op, src, level, now_ms, delivered, input ready);
	modport sink   (input valid, op, src, level, now_ms, delivered, output ready);
endinterface

interface pnt_res_if;
	logic                           valid;
	logic                           ready;
	logic [pnt_pkg::STATUS_W-1:0]   status;
	logic [pnt_pkg::SRC_W-1:0]      source_out;
	logic [pnt_pkg::LEVEL_W-1:0]    level_out;
	logic [pnt_pkg::SLOT_W-1:0]     attr_slot;

	modport source (output valid, status, source_out, level_out, attr_slot, input ready);
	modport sink   (input valid, status, source_out, level_out, attr_slot, output ready);
endinterface

`default_nettype wire

/* design/per_source_notify_throttle_core.sv */
// Per-source notify throttle top level: stage 1 register, decision, result register.
// Depends on pnt_pkg, pnt_if, pnt_cfg_regs, pnt_entry_table and pnt_decide.
//
//   channel  dir  handshake            payload
//   evt      in   valid/ready          op, src, level, now_ms, delivered
//   res      out  valid/ready          status, source_out, level_out, attr_slot
//   apb      in   psel/penable/pready  paddr, pwdata, prdata
//
// One word a cycle sustained while the result side takes them; a word goes from stage 1
// through the decision into the result register. The single decision pass and the
// history table (read at accept, written as a word leaves stage 1) allow that rate.
// Reset clears valid marks and control flops at once, no clearing pass. A stalled result
// holds stage 1; while stage 1 can move on, a new word is taken in the same cycle.
`default_nettype none

module per_source_notify_throttle_core #(
	parameter int NUM_SOURCES = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	pnt_evt_if.sink                            evt,
	pnt_res_if.source                          res,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pnt_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [pnt_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [pnt_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);

	localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

	pnt_pkg::cfg_t                  cfg;

	logic                           valid_s1;
	logic [pnt_pkg::OP_W-1:0]       op_s1;
	logic [pnt_pkg::SRC_W-1:0]      source_s1;
	logic [pnt_pkg::LEVEL_W-1:0]    level_s1;
	logic [pnt_pkg::TIME_W-1:0]     now_s1;
	logic                           delivered_s1;

	logic                           res_valid_q;
	pnt_pkg::status_t               status_q;
	logic [pnt_pkg::SRC_W-1:0]      source_q;
	logic [pnt_pkg::LEVEL_W-1:0]    level_q;
	logic [pnt_pkg::SLOT_W-1:0]     slot_q;

	logic                           accept;
	logic                           advance;
	logic                           rd_en;
	pnt_pkg::entry_t                rd_entry;
	logic                           cur_valid;
	pnt_pkg::entry_t                wr_entry;
	pnt_pkg::status_t               status_d;
	logic [pnt_pkg::SLOT_W-1:0]     slot_d;
	pnt_pkg::upd_t                  upd_d;
	pnt_pkg::upd_t                  upd;

	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign evt.ready = !valid_s1 || advance;
	assign accept    = evt.valid && evt.ready;
	assign rd_en     = accept && (evt.src < pnt_pkg::SRC_W'(NUM_SOURCES));

	pnt_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1        <= evt.op;
			source_s1    <= evt.src;
			level_s1     <= evt.level;
			now_s1       <= evt.now_ms;
			delivered_s1 <= evt.delivered;
		end
	end

	assign wr_entry.last_level = level_s1;
	assign wr_entry.last_time  = now_s1;
	assign upd.record          = advance && upd_d.record;
	assign upd.clear           = advance && upd_d.clear;

	pnt_entry_table #(
		.NUM_SOURCES (NUM_SOURCES),
		.IDX_W       (IDX_W)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (rd_en),
		.rd_idx    (evt.src[IDX_W-1:0]),
		.rd_entry  (rd_entry),
		.cur_idx   (source_s1[IDX_W-1:0]),
		.cur_valid (cur_valid),
		.upd       (upd),
		.wr_entry  (wr_entry)
	);

	pnt_decide #(
		.NUM_SOURCES (NUM_SOURCES)
	) u_decide (
		.op          (op_s1),
		.source      (source_s1),
		.level       (level_s1),
		.now_ms      (now_s1),
		.delivered   (delivered_s1),
		.cfg         (cfg),
		.entry       (rd_entry),
		.entry_valid (cur_valid),
		.status      (status_d),
		.attr_slot   (slot_d),
		.upd         (upd_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status_d;
			source_q <= source_s1;
			level_q  <= level_s1;
			slot_q   <= slot_d;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.status     = status_q;
	assign res.source_out = source_q;
	assign res.level_out  = level_q;
	assign res.attr_slot  = slot_q;

endmodule

`default_nettype wire

/* design/pnt_cfg_regs.sv */
// APB register bank: enable, critical level, hysteresis, minimum interval.
// Depends on pnt_pkg; the interval is kept in ms as well as in seconds.
`default_nettype none

module pnt_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pnt_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [pnt_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [pnt_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready,
	output pnt_pkg::cfg_t                      cfg
);

	logic                           enable_q;
	logic [pnt_pkg::LEVEL_W-1:0]    critical_q;
	logic [pnt_pkg::LEVEL_W-1:0]    hyst_q;
	logic [pnt_pkg::IVL_S_W-1:0]    ivl_s_q;
	logic [pnt_pkg::IVL_MS_W-1:0]   ivl_ms_q;
	logic                           wr_en;
	pnt_pkg::reg_idx_t              reg_idx;
	logic [pnt_pkg::IVL_MS_W-1:0]   wr_ivl_ms;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = pnt_pkg::reg_idx_t'(paddr[3:2]);
	// seconds to ms by a constant multiply, done once at write time
	assign wr_ivl_ms = pnt_pkg::IVL_MS_W'(pwdata[pnt_pkg::IVL_S_W-1:0]) *
	                   pnt_pkg::IVL_MS_W'(pnt_pkg::MS_PER_S);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= pnt_pkg::RST_ENABLE;
			critical_q <= pnt_pkg::RST_CRITICAL;
			hyst_q     <= pnt_pkg::RST_HYST;
			ivl_s_q    <= pnt_pkg::RST_IVL_S;
			ivl_ms_q   <= pnt_pkg::RST_IVL_MS;
		end else if (wr_en) begin
			unique case (reg_idx)
				pnt_pkg::REG_ENABLE:   enable_q   <= pwdata[0];
				pnt_pkg::REG_CRITICAL: critical_q <= pwdata[pnt_pkg::LEVEL_W-1:0];
				pnt_pkg::REG_HYST:     hyst_q     <= pwdata[pnt_pkg::LEVEL_W-1:0];
				pnt_pkg::REG_INTERVAL: begin
					ivl_s_q  <= pwdata[pnt_pkg::IVL_S_W-1:0];
					ivl_ms_q <= wr_ivl_ms;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			pnt_pkg::REG_ENABLE:   prdata = pnt_pkg::APB_DATA_W'(enable_q);
			pnt_pkg::REG_CRITICAL: prdata = pnt_pkg::APB_DATA_W'(critical_q);
			pnt_pkg::REG_HYST:     prdata = pnt_pkg::APB_DATA_W'(hyst_q);
			pnt_pkg::REG_INTERVAL: prdata = pnt_pkg::APB_DATA_W'(ivl_s_q);
			default:               prdata = '0;
		endcase
	end

	assign cfg.enable      = enable_q;
	assign cfg.critical    = critical_q;
	assign cfg.hyst        = hyst_q;
	assign cfg.interval_ms = ivl_ms_q;

endmodule

`default_nettype wire

/* design/pnt_entry_table.sv */
// Per-source history: last level and time in a memory, valid marks in flops.
// Depends on pnt_pkg. Read is registered at accept time with write bypass.
`default_nettype none

module pnt_entry_table #(
	parameter int NUM_SOURCES = 4,
	parameter int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [IDX_W-1:0]    rd_idx,
	output pnt_pkg::entry_t     rd_entry,
	input  logic [IDX_W-1:0]    cur_idx,
	output logic                cur_valid,
	input  pnt_pkg::upd_t       upd,
	input  pnt_pkg::entry_t     wr_entry
);

	pnt_pkg::entry_t            mem [NUM_SOURCES];
	logic [NUM_SOURCES-1:0]     valid_q;
	pnt_pkg::entry_t            rd_entry_q;

	always_ff @(posedge clk) begin
		if (upd.record) begin
			mem[cur_idx] <= wr_entry;
		end
	end

	// the item leaving stage 1 may write the entry the next item reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (upd.record && (cur_idx == rd_idx)) begin
				rd_entry_q <= wr_entry;
			end else begin
				rd_entry_q <= mem[rd_idx];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (upd.record) begin
			valid_q[cur_idx] <= 1'b1;
		end else if (upd.clear) begin
			valid_q[cur_idx] <= 1'b0;
		end
	end

	assign rd_entry  = rd_entry_q;
	assign cur_valid = valid_q[cur_idx];

endmodule

`default_nettype wire

/* design/pnt_decide.sv */
// Throttle decision for one word: range check, suppression test, table update.
// Depends on pnt_pkg. Purely combinational, sits between stage 1 and result.
`default_nettype none

module pnt_decide #(
	parameter int NUM_SOURCES = 4
) (
	input  logic [pnt_pkg::OP_W-1:0]     op,
	input  logic [pnt_pkg::SRC_W-1:0]    source,
	input  logic [pnt_pkg::LEVEL_W-1:0]  level,
	input  logic [pnt_pkg::TIME_W-1:0]   now_ms,
	input  logic                         delivered,
	input  pnt_pkg::cfg_t                cfg,
	input  pnt_pkg::entry_t              entry,
	input  logic                         entry_valid,
	output pnt_pkg::status_t             status,
	output logic [pnt_pkg::SLOT_W-1:0]   attr_slot,
	output pnt_pkg::upd_t                upd
);

	logic                           in_range;
	logic                           is_level;
	logic [pnt_pkg::LEVEL_W-1:0]    delta;
	logic [pnt_pkg::TIME_W:0]       elapsed;
	logic                           recent;
	logic                           suppress;
	logic [pnt_pkg::SLOT_W-1:0]     slot;

	assign in_range = (source < pnt_pkg::SRC_W'(NUM_SOURCES));
	assign is_level = (pnt_pkg::op_t'(op) == pnt_pkg::OP_LEVEL);

	assign delta = (level >= entry.last_level) ? (level - entry.last_level)
	                                           : (entry.last_level - level);

	// top bit is the borrow: time went backwards, which counts as recent
	assign elapsed = {1'b0, now_ms} - {1'b0, entry.last_time};
	assign recent  = elapsed[pnt_pkg::TIME_W] ||
	                 (elapsed[pnt_pkg::TIME_W-1:0] <
	                  pnt_pkg::TIME_W'(cfg.interval_ms));

	// level zero drops the valid mark and is excluded here, so it never suppresses
	assign suppress = cfg.enable && entry_valid && (level != '0) &&
	                  (level > cfg.critical) && (delta < cfg.hyst) && recent;

	// 5*source+1
	assign slot = {1'b0, source, 2'b00} + {3'b000, source} + pnt_pkg::SLOT_W'(1);

	always_comb begin
		status     = pnt_pkg::ST_NOTIFY;
		attr_slot  = '0;
		upd.record = 1'b0;
		upd.clear  = 1'b0;
		if (!in_range) begin
			status = pnt_pkg::ST_RANGE;
		end else if (!is_level) begin
			status     = pnt_pkg::ST_DONE;
			upd.record = delivered;
		end else begin
			upd.clear = (level == '0);
			if (suppress) begin
				status = pnt_pkg::ST_SUPPRESSED;
			end else begin
				status    = pnt_pkg::ST_NOTIFY;
				attr_slot = slot;
			end
		end
	end

endmodule

`default_nettype wire

/* design/pnt_checker.sv */
// Port-level checks on the throttle results, bound onto the top level.
// Depends on pnt_pkg and per_source_notify_throttle_core_defines.svh.
`default_nettype none
`include "per_source_notify_throttle_core_defines.svh"

module pnt_checker #(
	parameter int NUM_SOURCES = 4
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               res_valid,
	input logic                               res_ready,
	input logic [pnt_pkg::STATUS_W-1:0]       status,
	input logic [pnt_pkg::SRC_W-1:0]          source_out,
	input logic [pnt_pkg::LEVEL_W-1:0]        level_out,
	input logic [pnt_pkg::SLOT_W-1:0]         attr_slot
);

	logic [pnt_pkg::SLOT_W-1:0] exp_slot;
	logic                       is_range;
	logic                       is_notify;
	logic                       is_suppr;

	assign is_range  = (status == pnt_pkg::ST_RANGE);
	assign is_notify = (status == pnt_pkg::ST_NOTIFY);
	assign is_suppr  = (status == pnt_pkg::ST_SUPPRESSED);
	assign exp_slot  = is_notify ? (pnt_pkg::SLOT_W'(source_out) * 11'd5 + 11'd1) : '0;

	// stalled word holds
	`PNT_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable({status, source_out, level_out, attr_slot}))
	// range status exactly for sources beyond the table
	`PNT_ASSERT_NOW(a_range, clk, arst_n, res_valid, is_range == (source_out >= pnt_pkg::SRC_W'(NUM_SOURCES)))
	// slot only on a notify, and then five times source plus one
	`PNT_ASSERT_NOW(a_slot, clk, arst_n, res_valid, attr_slot == exp_slot)
	// level zero drops history, so it can never be suppressed
	`PNT_ASSERT_NOW(a_zero_level, clk, arst_n, res_valid && is_suppr, level_out != '0)

endmodule

bind per_source_notify_throttle_core pnt_checker #(
	.NUM_SOURCES (NUM_SOURCES)
) u_pnt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.status     (res.status),
	.source_out (res.source_out),
	.level_out  (res.level_out),
	.attr_slot  (res.attr_slot)
);

`default_nettype wire

/* tb/sv/per_source_notify_throttle_core_tb.sv */
// Self-checking bench for per_source_notify_throttle_core: directed and random level
// events and completions, random idling and long result stalls, APB programming.
// Needs pnt_pkg, pnt_if and the RTL of the block; reads nothing else.
`timescale 1ns / 1ps

module per_source_notify_throttle_core_tb;
	import pnt_pkg::*;

	localparam int NUM_SRC     = 4;
	localparam int HOLD_CYCLES = 400;
	localparam int RAND_PHASES = 12;
	localparam int PHASE_WORDS = 145;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	typedef struct {
		op_t                op;
		logic [SRC_W-1:0]   source;
		logic [LEVEL_W-1:0] level;
		logic [TIME_W-1:0]  now_ms;
		logic               delivered;
	} evt_word_t;

	typedef struct {
		status_t            status;
		logic [SRC_W-1:0]   source;
		logic [LEVEL_W-1:0] level;
		logic [SLOT_W-1:0]  slot;
	} res_word_t;

	// own copy of the throttle state; predicts one result per accepted word
	class throttle_scoreboard;
		bit                  enable;
		logic [LEVEL_W-1:0]  critical;
		logic [LEVEL_W-1:0]  hyst;
		logic [IVL_S_W-1:0]  interval_s;
		logic [LEVEL_W-1:0]  last_level [NUM_SRC];
		logic [TIME_W-1:0]   last_time [NUM_SRC];
		bit                  entry_valid [NUM_SRC];
		res_word_t           pending_outcomes [$];
		int unsigned         mismatches;

		function new();
			enable     = RST_ENABLE;
			critical   = RST_CRITICAL;
			hyst       = RST_HYST;
			interval_s = RST_IVL_S;
			foreach (entry_valid[i]) begin
				entry_valid[i] = 1'b0;
				last_level[i]  = '0;
				last_time[i]   = '0;
			end
			mismatches = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] v);
			case (idx)
				REG_ENABLE:   enable = v[0];
				REG_CRITICAL: critical = v[LEVEL_W-1:0];
				REG_HYST:     hyst = v[LEVEL_W-1:0];
				REG_INTERVAL: interval_s = v[IVL_S_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [APB_DATA_W-1:0] reg_value(reg_idx_t idx);
			case (idx)
				REG_ENABLE:   return APB_DATA_W'(enable);
				REG_CRITICAL: return APB_DATA_W'(critical);
				REG_HYST:     return APB_DATA_W'(hyst);
				default:      return APB_DATA_W'(interval_s);
			endcase
		endfunction

		function void fail(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t ns: mismatch: %s", $time, msg);
		endfunction

		function void note_word(evt_word_t w);
			res_word_t exp;
			int s;
			logic [LEVEL_W-1:0] delta;
			longint unsigned elapsed, limit;
			bit recent, quiet;
			s = w.source;
			exp.source = w.source;
			exp.level  = w.level;
			exp.slot   = '0;
			if (s >= NUM_SRC) begin
				exp.status = ST_RANGE;
			end else if (w.op == OP_COMPLETE) begin
				if (w.delivered) begin
					last_level[s]  = w.level;
					last_time[s]   = w.now_ms;
					entry_valid[s] = 1'b1;
				end
				exp.status = ST_DONE;
			end else begin
				// level zero drops the history before the test
				if (w.level == '0)
					entry_valid[s] = 1'b0;
				quiet = 1'b0;
				if (enable && entry_valid[s] && w.level > critical) begin
					delta = (w.level >= last_level[s]) ? w.level - last_level[s]
						: last_level[s] - w.level;
					// time running backwards counts as recent
					if (w.now_ms < last_time[s]) begin
						recent = 1'b1;
					end else begin
						elapsed = longint'(w.now_ms) - longint'(last_time[s]);
						limit   = longint'(interval_s) * MS_PER_S;
						recent  = elapsed < limit;
					end
					quiet = (delta < hyst) && recent;
				end
				if (quiet) begin
					exp.status = ST_SUPPRESSED;
				end else begin
					exp.status = ST_NOTIFY;
					exp.slot   = SLOT_W'(5 * s + 1);
				end
			end
			pending_outcomes.push_back(exp);
		endfunction

		function void check_word(res_word_t got);
			res_word_t exp;
			if (pending_outcomes.size() == 0) begin
				fail($sformatf("unexpected word status %0d source %0d level %0d slot %0d",
					got.status, got.source, got.level, got.slot));
				return;
			end
			exp = pending_outcomes.pop_front();
			if (got.status !== exp.status)
				fail($sformatf("source %0d status exp %0d got %0d",
					exp.source, exp.status, got.status));
			if (got.source !== exp.source)
				fail($sformatf("source_out exp %0d got %0d", exp.source, got.source));
			if (got.level !== exp.level)
				fail($sformatf("source %0d level_out exp %0d got %0d",
					exp.source, exp.level, got.level));
			if (got.slot !== exp.slot)
				fail($sformatf("source %0d attr_slot exp %0d got %0d",
					exp.source, exp.slot, got.slot));
		endfunction

		function int outstanding();
			return pending_outcomes.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	pnt_evt_if evt_ch ();
	pnt_res_if res_ch ();

	throttle_scoreboard sb;
	bit tx_quiet;
	bit rx_quiet;
	bit hold_off_due;

	// stimulus-side guess of each source's history, steers near-miss words
	logic [LEVEL_W-1:0] stim_level [NUM_SRC];
	longint unsigned    stim_time [NUM_SRC];

	per_source_notify_throttle_core #(
		.NUM_SOURCES(NUM_SRC)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.evt(evt_ch),
		.res(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (evt_ch.valid === 1'b1 && evt_ch.ready === 1'b1)
				sb.note_word('{op_t'(evt_ch.op), evt_ch.src, evt_ch.level,
					evt_ch.now_ms, evt_ch.delivered});
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
				sb.check_word('{status_t'(res_ch.status), res_ch.source_out,
					res_ch.level_out, res_ch.attr_slot});
		end
	end

	// result side: random stall per word, plus one long hold when asked
	initial begin : sink_side
		int stall;
		res_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_off_due) begin
				hold_off_due = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = rx_quiet ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (res_ch.valid !== 1'b1);
		end
	end

	initial begin : watchdog
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic evt_word_t mk(op_t op, int src, int lvl, logic [TIME_W-1:0] t,
		bit dlv);
		evt_word_t w;
		w.op        = op;
		w.source    = SRC_W'(src);
		w.level     = LEVEL_W'(lvl);
		w.now_ms    = t;
		w.delivered = dlv;
		return w;
	endfunction

	task automatic offer_word(input evt_word_t w);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			evt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_ch.valid     <= 1'b1;
		evt_ch.op        <= w.op;
		evt_ch.src       <= w.source;
		evt_ch.level     <= w.level;
		evt_ch.now_ms    <= w.now_ms;
		evt_ch.delivered <= w.delivered;
		do @(posedge clk); while (evt_ch.ready !== 1'b1);
	endtask

	// stop offering and wait until every predicted word has come out
	task automatic settle();
		evt_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'({idx, 2'b00});
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.write_reg(idx, v);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic cfg_read(input reg_idx_t idx, output logic [APB_DATA_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= APB_ADDR_W'({idx, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		v = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_cfg_regs();
		reg_idx_t idx;
		logic [APB_DATA_W-1:0] v;
		idx = idx.first();
		do begin
			cfg_read(idx, v);
			if (v !== sb.reg_value(idx))
				sb.fail($sformatf("register %s read %0h, holds %0h", idx.name(), v,
					sb.reg_value(idx)));
			idx = idx.next();
		end while (idx != idx.first());
	endtask

	task automatic set_config(input bit en, input int unsigned crit, input int unsigned hy,
		input int unsigned iv);
		cfg_write(REG_ENABLE, APB_DATA_W'(en));
		cfg_write(REG_CRITICAL, APB_DATA_W'(crit));
		cfg_write(REG_HYST, APB_DATA_W'(hy));
		cfg_write(REG_INTERVAL, APB_DATA_W'(iv));
		check_cfg_regs();
	endtask

	function automatic evt_word_t random_word();
		evt_word_t w;
		int pick, s, lv, h;
		longint unsigned ivl_ms, t;
		pick   = $urandom_range(0, 99);
		s      = $urandom_range(0, NUM_SRC - 1);
		h      = sb.hyst;
		ivl_ms = longint'(sb.interval_s) * MS_PER_S;
		w.op        = OP_LEVEL;
		w.source    = SRC_W'(s);
		w.level     = LEVEL_W'($urandom_range(0, 127));
		w.now_ms    = TIME_W'({$urandom, $urandom});
		w.delivered = $urandom_range(0, 1);
		if (pick < 30) begin
			w.op        = OP_COMPLETE;
			w.delivered = 1'b1;
			if ($urandom_range(0, 9) != 0)
				w.now_ms = TIME_W'(stim_time[s] + $urandom_range(0, 32'(ivl_ms * 2 + 10)));
			stim_level[s] = w.level;
			stim_time[s]  = w.now_ms;
		end else if (pick < 70) begin
			// close to the recorded history, around the hysteresis and interval edges
			lv = int'(stim_level[s]) + int'($urandom_range(0, 2 * h + 2)) - (h + 1);
			if (lv < 0)
				lv = 0;
			if (lv > 127)
				lv = 127;
			w.level = LEVEL_W'(lv);
			case ($urandom_range(0, 5))
				0: t = stim_time[s] + $urandom_range(0, 32'(ivl_ms));
				1: t = stim_time[s] + ivl_ms - 1;
				2: t = stim_time[s] + ivl_ms;
				3: t = stim_time[s] + ivl_ms + 1 + $urandom_range(0, 5000);
				4: t = stim_time[s] - $urandom_range(1, 5000);
				default: t = stim_time[s] + $urandom_range(0, 3000);
			endcase
			w.now_ms = TIME_W'(t);
		end else if (pick < 80) begin
			// fully random level event
		end else if (pick < 85) begin
			w.level  = '0;
			w.now_ms = TIME_W'(stim_time[s] + $urandom_range(0, 1000));
		end else if (pick < 92) begin
			w.op        = OP_COMPLETE;
			w.delivered = 1'b0;
		end else begin
			w.source = SRC_W'($urandom_range(NUM_SRC, 255));
			w.op     = op_t'($urandom_range(0, 1));
		end
		return w;
	endfunction

	initial begin : stimulus
		int ph, n;
		sb = new();
		arst_n           <= 1'b0;
		psel             <= 1'b0;
		penable          <= 1'b0;
		pwrite           <= 1'b0;
		paddr            <= '0;
		pwdata           <= '0;
		evt_ch.valid     <= 1'b0;
		evt_ch.op        <= OP_LEVEL;
		evt_ch.src       <= '0;
		evt_ch.level     <= '0;
		evt_ch.now_ms    <= '0;
		evt_ch.delivered <= 1'b0;
		tx_quiet     = 1'b0;
		rx_quiet     = 1'b0;
		hold_off_due = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_cfg_regs();

		// reset settings: hysteresis, interval edge, critical floor, backwards time
		offer_word(mk(OP_LEVEL, 0, 50, 0, 0));
		offer_word(mk(OP_COMPLETE, 0, 50, 1000, 1));
		offer_word(mk(OP_LEVEL, 0, 51, 2000, 0));
		offer_word(mk(OP_LEVEL, 0, 52, 3000, 1));
		offer_word(mk(OP_LEVEL, 0, 50, 60999, 0));
		offer_word(mk(OP_LEVEL, 0, 50, 61000, 0));
		offer_word(mk(OP_LEVEL, 0, 49, 500, 0));
		offer_word(mk(OP_COMPLETE, 1, 16, 0, 1));
		offer_word(mk(OP_LEVEL, 1, 16, 10, 0));
		offer_word(mk(OP_LEVEL, 1, 15, 10, 0));
		// failed completion leaves the old history in place
		offer_word(mk(OP_COMPLETE, 1, 90, 20, 0));
		offer_word(mk(OP_LEVEL, 1, 17, 30, 0));
		offer_word(mk(OP_LEVEL, 4, 50, 0, 0));
		offer_word(mk(OP_LEVEL, 255, 127, TIME_MAX, 1));
		offer_word(mk(OP_COMPLETE, 255, 0, 0, 1));
		offer_word(mk(OP_COMPLETE, 3, 100, TIME_MAX, 1));
		offer_word(mk(OP_LEVEL, 3, 101, 0, 0));
		offer_word(mk(OP_LEVEL, 3, 127, TIME_MAX, 0));
		offer_word(mk(OP_LEVEL, 2, 0, 0, 0));

		settle();
		tx_quiet = 1'b1;
		set_config(1'b1, 0, 127, 4095);
		// level zero wipes the entry, so the repeat goes out
		offer_word(mk(OP_COMPLETE, 2, 10, 100, 1));
		offer_word(mk(OP_LEVEL, 2, 0, 101, 0));
		offer_word(mk(OP_LEVEL, 2, 10, 102, 0));
		offer_word(mk(OP_COMPLETE, 2, 1, 200, 1));
		offer_word(mk(OP_LEVEL, 2, 1, 201, 0));

		settle();
		set_config(1'b0, 0, 127, 4095);
		offer_word(mk(OP_COMPLETE, 0, 60, 0, 1));
		offer_word(mk(OP_LEVEL, 0, 60, 1, 0));

		foreach (stim_level[i]) begin
			stim_level[i] = LEVEL_W'($urandom_range(0, 127));
			stim_time[i]  = (i == 0) ? longint'(TIME_MAX) - 1000
				: longint'(TIME_W'({$urandom, $urandom}));
		end

		for (ph = 0; ph < RAND_PHASES; ph++) begin
			settle();
			case (ph)
				0: set_config(1'b1, 15, 2, 60);
				1: set_config(1'b1, 0, 127, 4095);
				2: set_config(1'b1, 127, 0, 0);
				3: set_config(1'b0, $urandom_range(0, 127), $urandom_range(0, 127),
					$urandom_range(0, 4095));
				4: set_config(1'b1, 0, 127, 0);
				default: set_config($urandom_range(0, 3) != 0, $urandom_range(0, 60),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
						: $urandom_range(0, 20),
					$urandom_range(0, 4095));
			endcase
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			for (n = 0; n < PHASE_WORDS; n++) begin
				// long result stall while words keep coming
				if ((ph == 2 || ph == 7) && n == 30) begin
					tx_quiet     = 1'b1;
					hold_off_due = 1'b1;
				end
				offer_word(random_word());
			end
		end

		settle();
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
